/* design/rn2a_pkg.sv */
// Shared constants and helpers for the radix number-to-ASCII converter.
`default_nettype none

package rn2a_pkg;

  localparam int VALUE_BITS_DEF = 32;   // default arithmetic width of the word
  localparam int VALUE_W        = 32;   // width of the value field
  localparam int RADIX_W        = 5;    // width of the radix field
  localparam int CHAR_W         = 7;    // width of an ASCII character
  localparam int DIGIT_W        = 4;    // one digit of a base up to sixteen
  localparam int STEP_BITS      = 8;    // quotient bits resolved per cycle

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h57;  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;  // '-'

  // Map a digit 0..15 to its lower-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_ALPHA + ext;
    end
  endfunction

endpackage

`default_nettype wire

/* design/rn2a_if.sv */
// Handshake channels: number in, character out.
`default_nettype none

interface rn2a_num_if;
  logic                             valid;
  logic                             ready;
  logic [rn2a_pkg::VALUE_W-1:0]     value;
  logic [rn2a_pkg::RADIX_W-1:0]     radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rn2a_char_if;
  logic                             valid;
  logic                             ready;
  logic [rn2a_pkg::CHAR_W-1:0]      ascii_char;
  logic                             last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

/* design/rn2a_div_step.sv */
// Restoring divider slice: resolves STEP_BITS quotient bits of a word by the radix.
`default_nettype none

module rn2a_div_step #(
  parameter int W = 32
) (
  input  wire logic [W-1:0]                    quo_in,
  input  wire logic [rn2a_pkg::DIGIT_W-1:0]    rem_in,
  input  wire logic [rn2a_pkg::RADIX_W-1:0]    radix,
  output logic      [W-1:0]                    quo_out,
  output logic      [rn2a_pkg::DIGIT_W-1:0]    rem_out
);

  // Remainder stays below the radix, so it fits in one digit; the shifted
  // partial remainder fits in the radix width.
  always_comb begin
    logic [W-1:0]                  q;
    logic [rn2a_pkg::DIGIT_W-1:0]  r;
    logic [rn2a_pkg::RADIX_W-1:0]  t;
    q = quo_in;
    r = rem_in;
    for (int k = 0; k < rn2a_pkg::STEP_BITS; k++) begin
      t = {r, q[W-1]};
      q = {q[W-2:0], 1'b0};
      if (t >= radix) begin
        t    = t - radix;
        q[0] = 1'b1;
      end
      r = t[rn2a_pkg::DIGIT_W-1:0];
    end
    quo_out = q;
    rem_out = r;
  end

endmodule

`default_nettype wire

/* design/radix_number_to_ascii_top.sv */
// Top level of the radix number-to-ASCII converter.
// Converts one word per input beat into its ASCII digits in the given base
// (2..16, anything else means 16), most significant first, lower case, no
// leading zeros; base ten reads the word as signed and leads a negative one with '-'.
// One character leaves per output beat, the final one with last_char set.
// A shared restoring divider resolves eight quotient bits per cycle and
// divides the word by the base once per digit until the quotient is zero;
// the characters (sign included) then leave one per cycle while the sink
// takes them. The input is not ready until the last character is in the
// output register.
`default_nettype none

module radix_number_to_ascii_top #(
  parameter int VALUE_BITS = rn2a_pkg::VALUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rn2a_num_if.sink         num_in,
  rn2a_char_if.source      chr_out
);

  localparam int DIV_CYCLES = (VALUE_BITS + rn2a_pkg::STEP_BITS - 1) / rn2a_pkg::STEP_BITS;
  localparam int W          = DIV_CYCLES * rn2a_pkg::STEP_BITS;
  localparam int CW         = $clog2(DIV_CYCLES + 1);
  localparam int NDW        = $clog2(VALUE_BITS + 1);
  localparam int DW         = rn2a_pkg::DIGIT_W;

  localparam logic [W-1:0] VMASK = W'({VALUE_BITS{1'b1}});

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                    state;
  logic [W-1:0]                  quo;
  logic [DW-1:0]                 rem;
  logic [rn2a_pkg::RADIX_W-1:0]  base;
  logic [CW-1:0]                 cnt;
  logic [NDW-1:0]                ndig;
  logic                          neg_pend;
  logic [DW-1:0]                 stack [VALUE_BITS];

  logic                          ovalid;
  logic [rn2a_pkg::CHAR_W-1:0]   ochar;
  logic                          olast;

  logic [W-1:0]                  quo_o;
  logic [DW-1:0]                 rem_o;
  logic [W-1:0]                  v_in;
  logic [rn2a_pkg::RADIX_W-1:0]  base_in;
  logic                          neg_in;
  logic                          in_fire;
  logic                          out_free;
  logic                          div_done;

  rn2a_div_step #(.W(W)) u_div (
    .quo_in  (quo),
    .rem_in  (rem),
    .radix   (base),
    .quo_out (quo_o),
    .rem_out (rem_o)
  );

  assign num_in.ready      = (state == S_IDLE);
  assign in_fire           = num_in.valid && num_in.ready;
  assign out_free          = !ovalid || chr_out.ready;
  assign div_done          = (cnt == CW'(DIV_CYCLES - 1));

  assign chr_out.valid      = ovalid;
  assign chr_out.ascii_char = ochar;
  assign chr_out.last_char  = olast;

  always_comb begin
    v_in = W'(num_in.value) & VMASK;
    if (num_in.radix < rn2a_pkg::RADIX_MIN || num_in.radix > rn2a_pkg::RADIX_MAX) begin
      base_in = rn2a_pkg::RADIX_MAX;
    end else begin
      base_in = num_in.radix;
    end
    neg_in = (base_in == rn2a_pkg::RADIX_DEC) && v_in[VALUE_BITS-1];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      ndig     <= '0;
      neg_pend <= 1'b0;
      ovalid   <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        ovalid <= 1'b1;
      end else if (chr_out.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state    <= S_DIV;
            cnt      <= '0;
            ndig     <= '0;
            neg_pend <= neg_in;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cnt  <= '0;
            ndig <= ndig + NDW'(1);
            if (quo_o == '0) begin
              state <= S_EMIT;
            end
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (neg_pend) begin
              neg_pend <= 1'b0;
            end else begin
              ndig <= ndig - NDW'(1);
              if (ndig == NDW'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: working word, remainder, digit stack and output payload.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          base <= base_in;
          rem  <= '0;
          quo  <= neg_in ? ((~v_in + W'(1)) & VMASK) : v_in;
        end
      end
      S_DIV: begin
        quo <= quo_o;
        if (div_done) begin
          rem <= '0;
          // push the new digit; digits come out least significant first
          for (int i = VALUE_BITS - 1; i > 0; i--) begin
            stack[i] <= stack[i-1];
          end
          stack[0] <= rem_o;
        end else begin
          rem <= rem_o;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (neg_pend) begin
            ochar <= rn2a_pkg::CHAR_MINUS;
            olast <= 1'b0;
          end else begin
            ochar <= rn2a_pkg::digit_char(stack[0]);
            olast <= (ndig == NDW'(1));
            // pop the most significant remaining digit
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
              stack[i] <= stack[i+1];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (ndig == '0))
    else $error("digit stack not empty while idle");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (ndig != '0))
    else $error("emitting with no digit left");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem} < base))
    else $error("divider remainder out of range");

  a_sign_decimal: assert property (@(posedge clk) disable iff (rst)
    (neg_pend && state != S_IDLE) |-> (base == rn2a_pkg::RADIX_DEC))
    else $error("sign pending outside base ten");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && !neg_pend && ndig == NDW'(1)) |=>
      (state == S_IDLE && chr_out.valid && chr_out.last_char))
    else $error("final character not flagged");

endmodule

`default_nettype wire

/* bench/radix_number_to_ascii_top_tb.sv */
// Self-checking bench for the radix number-to-ASCII converter.
`timescale 1ns / 100ps

module radix_number_to_ascii_top_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_ITEMS  = 60;
  localparam int RANDOM_ITEMS = 410;
  localparam int MAX_PRINTS  = 30;
  localparam logic [rn2a_pkg::CHAR_W-1:0] CHAR_LOWER_A = 7'h61;  // 'a'

  typedef struct packed {
    logic [rn2a_pkg::VALUE_W-1:0] value;
    logic [rn2a_pkg::RADIX_W-1:0] radix;
    logic                         wait_idle;
  } number_item_t;

  typedef struct packed {
    logic [rn2a_pkg::CHAR_W-1:0] ascii_char;
    logic                        last_char;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rn2a_num_if  num_if ();
  rn2a_char_if chr_if ();

  radix_number_to_ascii_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .num_in  (num_if),
    .chr_out (chr_if)
  );

  number_item_t numbers_q[$];
  char_beat_t   due_chars[$];

  int unsigned cycle_cnt     = 0;
  int unsigned mismatches    = 0;
  int unsigned numbers_sent  = 0;
  int unsigned negative_dec  = 0;
  int unsigned odd_radix     = 0;
  int unsigned chars_seen    = 0;
  int unsigned numbers_seen  = 0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    num_if.valid   = 1'b0;
    num_if.value   = '0;
    num_if.radix   = '0;
    chr_if.ready   = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Spell a word in the given base and queue its characters.
  function automatic void spell_number(input logic [rn2a_pkg::VALUE_W-1:0] word,
                                       input logic [rn2a_pkg::RADIX_W-1:0] radix);
    logic [rn2a_pkg::VALUE_W-1:0] mag;
    logic [rn2a_pkg::VALUE_W-1:0] base;
    logic [rn2a_pkg::DIGIT_W-1:0] dig;
    logic [rn2a_pkg::DIGIT_W-1:0] digs[$];
    char_beat_t                   beat;
    if (radix < rn2a_pkg::RADIX_MIN || radix > rn2a_pkg::RADIX_MAX) begin
      base = rn2a_pkg::VALUE_W'(rn2a_pkg::RADIX_MAX);
      odd_radix++;
    end else begin
      base = rn2a_pkg::VALUE_W'(radix);
    end
    mag = word;
    if (base == rn2a_pkg::VALUE_W'(rn2a_pkg::RADIX_DEC) && word[rn2a_pkg::VALUE_W-1]) begin
      beat.ascii_char = rn2a_pkg::CHAR_MINUS;
      beat.last_char  = 1'b0;
      due_chars.push_back(beat);
      mag = -word;
      negative_dec++;
    end
    do begin
      digs.push_back(rn2a_pkg::DIGIT_W'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    while (digs.size() > 0) begin
      dig = digs.pop_back();
      if (dig < 4'd10) begin
        beat.ascii_char = rn2a_pkg::CHAR_ZERO + rn2a_pkg::CHAR_W'(dig);
      end else begin
        beat.ascii_char = CHAR_LOWER_A + rn2a_pkg::CHAR_W'(dig - 4'd10);
      end
      beat.last_char = (digs.size() == 0);
      due_chars.push_back(beat);
    end
  endfunction

  // Sender: offers queued numbers, with short gaps and drain pauses.
  int unsigned gap_left = 0;

  always @(posedge clk) begin : num_drive
    logic         offer;
    logic         bursty;
    number_item_t item;
    if (rst) begin
      num_if.valid <= 1'b0;
      num_if.value <= '0;
      num_if.radix <= '0;
      gap_left = 0;
    end else begin
      if (num_if.valid && num_if.ready) begin
        spell_number(num_if.value, num_if.radix);
        numbers_sent++;
      end
      if (!num_if.valid || num_if.ready) begin
        bursty = ((numbers_sent / 40) % 3 != 1) && (numbers_q.size() > CALM_ITEMS);
        offer  = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (numbers_q.size() == 0) begin
          offer = 1'b0;
        end else if (numbers_q[0].wait_idle && due_chars.size() != 0) begin
          offer = 1'b0;
        end else if (bursty && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 2);
        end else begin
          offer = 1'b1;
          item = numbers_q.pop_front();
          num_if.value <= item.value;
          num_if.radix <= item.radix;
        end
        num_if.valid <= offer;
      end
    end
  end

  // Receiver: checks each character beat, stalls in bursts and once at length.
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk) begin : chr_check
    char_beat_t want;
    logic       bursty;
    logic       take;
    if (rst) begin
      chr_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (chr_if.valid && chr_if.ready) begin
        chars_seen++;
        if (due_chars.size() == 0) begin
          flag_mismatch("unexpected character", 32'(chr_if.ascii_char), 32'd0);
        end else begin
          want = due_chars.pop_front();
          if (chr_if.ascii_char !== want.ascii_char) begin
            flag_mismatch("ascii_char", 32'(chr_if.ascii_char), 32'(want.ascii_char));
          end
          if (chr_if.last_char !== want.last_char) begin
            flag_mismatch("last_char", 32'(chr_if.last_char), 32'(want.last_char));
          end
        end
        if (chr_if.last_char) begin
          numbers_seen++;
        end
      end
      if (!long_hold_done && numbers_seen >= 120) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      bursty = ((numbers_seen / 40) % 3 != 2) && (numbers_q.size() > CALM_ITEMS);
      take   = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        take = 1'b0;
      end
      chr_if.ready <= take;
    end
  end

  function automatic number_item_t make_item(input logic [rn2a_pkg::VALUE_W-1:0] value,
                                             input logic [rn2a_pkg::RADIX_W-1:0] radix,
                                             input logic wait_idle);
    number_item_t item;
    item.value     = value;
    item.radix     = radix;
    item.wait_idle = wait_idle;
    return item;
  endfunction

  function automatic logic [rn2a_pkg::VALUE_W-1:0] pick_value();
    logic [rn2a_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: begin
        v = rn2a_pkg::VALUE_W'(1) << $urandom_range(0, rn2a_pkg::VALUE_W - 1);
        v = v + $urandom_range(0, 2) - 1;
      end
      3: v = -rn2a_pkg::VALUE_W'($urandom_range(1, 1000));
      4: v = $urandom >> $urandom_range(0, rn2a_pkg::VALUE_W - 1);
      default: v = $urandom | 32'h8000_0000;
    endcase
    return v;
  endfunction

  function automatic logic [rn2a_pkg::RADIX_W-1:0] pick_radix();
    int unsigned r;
    if ($urandom_range(0, 15) == 0) begin
      // out of range: 0, 1 or 17..31
      r = $urandom_range(0, 16);
      return (r < 2) ? rn2a_pkg::RADIX_W'(r) : rn2a_pkg::RADIX_W'(r + 15);
    end
    if ($urandom_range(0, 3) == 0) begin
      return rn2a_pkg::RADIX_DEC;
    end
    return rn2a_pkg::RADIX_W'($urandom_range(rn2a_pkg::RADIX_MIN, rn2a_pkg::RADIX_MAX));
  endfunction

  initial begin : stimulus
    logic [rn2a_pkg::RADIX_W-1:0] base_list[$];
    // zero, all ones, most negative and largest positive words
    numbers_q.push_back(make_item(32'h0000_0000, rn2a_pkg::RADIX_DEC, 1'b0));
    numbers_q.push_back(make_item(32'h0000_0000, 5'd2, 1'b0));
    numbers_q.push_back(make_item(32'h0000_0000, rn2a_pkg::RADIX_MAX, 1'b0));
    numbers_q.push_back(make_item(32'hffff_ffff, 5'd2, 1'b0));
    numbers_q.push_back(make_item(32'hffff_ffff, rn2a_pkg::RADIX_MAX, 1'b0));
    numbers_q.push_back(make_item(32'hffff_ffff, rn2a_pkg::RADIX_DEC, 1'b0));
    numbers_q.push_back(make_item(32'hffff_ffff, 5'd8, 1'b0));
    numbers_q.push_back(make_item(32'h8000_0000, rn2a_pkg::RADIX_DEC, 1'b0));
    numbers_q.push_back(make_item(32'h8000_0000, 5'd2, 1'b0));
    numbers_q.push_back(make_item(32'h7fff_ffff, rn2a_pkg::RADIX_DEC, 1'b0));
    // bases outside 2..16 fall back to hex
    numbers_q.push_back(make_item(32'h1234_5678, 5'd0, 1'b0));
    numbers_q.push_back(make_item(32'hdead_beef, 5'd1, 1'b0));
    numbers_q.push_back(make_item(32'hcafe_f00d, 5'd17, 1'b0));
    numbers_q.push_back(make_item(32'hffff_ffff, 5'd31, 1'b0));
    base_list = '{5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15};
    foreach (base_list[k]) begin
      numbers_q.push_back(make_item($urandom, base_list[k], 1'b0));
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      numbers_q.push_back(make_item(pick_value(), pick_radix(), (i % 70) == 0));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (numbers_q.size() != 0 || num_if.valid) @(posedge clk);
    while (due_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d words into %0d characters in %0d cycles.",
             numbers_sent, chars_seen, cycle_cnt);
    $display("Covered every base 2..16, %0d out-of-range bases, %0d negative decimals.",
             odd_radix, negative_dec);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timed out with %0d characters still due.", due_chars.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/rn2a_pkg.sv
design/rn2a_if.sv
design/rn2a_div_step.sv
design/radix_number_to_ascii_top.sv
bench/radix_number_to_ascii_top_tb.sv
